FILE: rtl/core/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Types and constants shared by the line substring filter files.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } lsf_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       status;
    logic       last;
  } lsf_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_BYTE,
    ST_NEWLINE,
    ST_STATUS
  } lsf_state_t;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic STATUS_MATCH   = 1'b0;
  localparam logic STATUS_NOMATCH = 1'b1;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int TLEN_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/lsf_ram.sv
// ----------------------------------------------------------------------------
// lsf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 31,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/line_substring_filter_top.sv
// ----------------------------------------------------------------------------
// line_substring_filter_top
// Fixed-string line filter: passes through text lines that hold the term.
// ----------------------------------------------------------------------------
// An ordinary text byte, carriage return or NUL is taken in the idle state, so
// plain text streams at one byte a cycle while no flush runs. A newline or
// end-of-input beat on a matched line walks the line RAM through its single
// read port: each stored byte passes the READ and BYTE states, then NEWLINE
// gives the closing newline and, at end of input, STATUS the status beat, each
// held while the result side stalls. Unmatched lines need no flush. The result
// register lets a new beat enter while the last result still waits to be taken.
`default_nettype none

module line_substring_filter_top #(
  parameter int LINE_BYTES = 32,
  parameter int TERM_BYTES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire lsf_pkg::lsf_item_t             item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output lsf_pkg::lsf_result_t                result,
  input  wire logic                           cfg_write,
  input  wire logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int STORE_DEPTH = LINE_BYTES - 1;
  localparam int CNT_W       = $clog2(LINE_BYTES);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CMP_W       = (CNT_W + 1 > lsf_pkg::TLEN_W) ? CNT_W + 1 : lsf_pkg::TLEN_W;

  // configuration
  logic [2*lsf_pkg::CFG_W-1:0] term;
  logic [lsf_pkg::TLEN_W-1:0]  term_size;

  // line state
  logic [CNT_W-1:0] count;
  logic [7:0]       win [TERM_BYTES];
  logic             line_matched;
  logic             found_any;

  // flush control
  lsf_pkg::lsf_state_t state, state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] flen;
  logic             pend_eoi;

  logic [7:0] ram_rdata;
  logic       ram_we;

  logic item_fire;
  logic out_free;
  logic is_drop;
  logic is_lf;
  logic do_store;
  logic hit;
  logic len_ok;
  logic [7:0] win_new [TERM_BYTES];

  logic                 load_out;
  lsf_pkg::lsf_result_t load_data;
  logic                 idx_step;

  assign item_fire = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign is_drop   = (item.in_byte == lsf_pkg::CHAR_CR) || (item.in_byte == lsf_pkg::CHAR_NUL);
  assign is_lf     = (item.in_byte == lsf_pkg::CHAR_LF);
  assign do_store  = item_fire && !item.end_of_input && !is_drop && !is_lf
                     && (count < CNT_W'(STORE_DEPTH));
  assign ram_we    = do_store;

  lsf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(item.in_byte),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // window after the incoming byte shifts in, and the term compare
  always_comb begin
    logic [3:0] k;
    win_new[0] = item.in_byte;
    for (int j = 1; j < TERM_BYTES; j++) begin
      win_new[j] = win[j-1];
    end
    len_ok = (term_size != '0) && (term_size <= lsf_pkg::TLEN_W'(TERM_BYTES))
             && ((CMP_W'(count) + CMP_W'(1)) >= CMP_W'(term_size));
    hit = len_ok;
    for (int j = 0; j < TERM_BYTES; j++) begin
      k = 4'(term_size - lsf_pkg::TLEN_W'(1) - lsf_pkg::TLEN_W'(j));
      if (lsf_pkg::TLEN_W'(j) < term_size) begin
        if (win_new[j] != term[k*8 +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsf_pkg::ST_IDLE: begin
        if (item_fire) begin
          if (item.end_of_input) begin
            state_next = (line_matched && count != '0) ? lsf_pkg::ST_READ : lsf_pkg::ST_STATUS;
          end else if (is_lf && line_matched) begin
            state_next = lsf_pkg::ST_READ;
          end
        end
      end
      lsf_pkg::ST_READ: begin
        state_next = lsf_pkg::ST_BYTE;
      end
      lsf_pkg::ST_BYTE: begin
        if (out_free) begin
          state_next = (idx + CNT_W'(1) == flen) ? lsf_pkg::ST_NEWLINE : lsf_pkg::ST_READ;
        end
      end
      lsf_pkg::ST_NEWLINE: begin
        if (out_free) begin
          state_next = pend_eoi ? lsf_pkg::ST_STATUS : lsf_pkg::ST_IDLE;
        end
      end
      lsf_pkg::ST_STATUS: begin
        if (out_free) begin
          state_next = lsf_pkg::ST_IDLE;
        end
      end
      default: state_next = lsf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall = 1'b1;
    load_out   = 1'b0;
    idx_step   = 1'b0;
    load_data  = '{out_byte: ram_rdata, kind: lsf_pkg::KIND_LINE,
                   status: lsf_pkg::STATUS_MATCH, last: 1'b0};
    unique case (state)
      lsf_pkg::ST_IDLE: begin
        item_stall = 1'b0;
      end
      lsf_pkg::ST_READ: begin
      end
      lsf_pkg::ST_BYTE: begin
        load_out = out_free;
        idx_step = out_free;
      end
      lsf_pkg::ST_NEWLINE: begin
        load_out           = out_free;
        load_data.out_byte = lsf_pkg::CHAR_LF;
        load_data.last     = !pend_eoi;
      end
      lsf_pkg::ST_STATUS: begin
        load_out           = out_free;
        load_data.out_byte = '0;
        load_data.kind     = lsf_pkg::KIND_STATUS;
        load_data.status   = found_any ? lsf_pkg::STATUS_MATCH : lsf_pkg::STATUS_NOMATCH;
        load_data.last     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      term      <= '0;
      term_size <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lsf_pkg::REG_TERM_LOW:  term[lsf_pkg::CFG_W-1:0] <= cfg_data;
        lsf_pkg::REG_TERM_HIGH: term[2*lsf_pkg::CFG_W-1:lsf_pkg::CFG_W] <= cfg_data;
        lsf_pkg::REG_TERM_LEN:  term_size <= cfg_data[lsf_pkg::TLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // line and flush state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lsf_pkg::ST_IDLE;
      count        <= '0;
      line_matched <= 1'b0;
      found_any    <= 1'b0;
      idx          <= '0;
      flen         <= '0;
      pend_eoi     <= 1'b0;
      for (int j = 0; j < TERM_BYTES; j++) begin
        win[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (idx_step) begin
        idx <= idx + CNT_W'(1);
      end
      if (load_out && state == lsf_pkg::ST_STATUS) begin
        found_any <= 1'b0;
      end
      if (do_store) begin
        count <= count + CNT_W'(1);
        for (int j = 0; j < TERM_BYTES; j++) begin
          win[j] <= win_new[j];
        end
        if (hit) begin
          line_matched <= 1'b1;
        end
      end else if (item_fire && (item.end_of_input || is_lf)) begin
        pend_eoi     <= item.end_of_input;
        idx          <= '0;
        flen         <= count;
        count        <= '0;
        line_matched <= 1'b0;
        if (line_matched && count != '0) begin
          found_any <= 1'b1;
        end
        for (int j = 0; j < TERM_BYTES; j++) begin
          win[j] <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: test/line_substring_filter_top_tb.sv
// ----------------------------------------------------------------------------
// line_substring_filter_top_tb
// Self-checking bench for the fixed-string line filter. A queue of text beats
// is driven through the valid/stall input, lines that hold the search term
// are predicted per accepted beat and compared field by field with every
// result beat, under several term settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module line_substring_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_BYTES       = 32;
  localparam int TERM_BYTES       = 16;
  localparam int SETTLE_CYCLES    = 100;
  localparam int LONG_HOLD        = 400;
  localparam int RANDOM_PER_PHASE = 82;
  localparam int CYCLE_LIMIT      = 400000;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  lsf_pkg::lsf_item_t            item         = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  lsf_pkg::lsf_result_t          result;
  logic                          cfg_write    = 1'b0;
  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index    = lsf_pkg::REG_TERM_LOW;
  logic [lsf_pkg::CFG_W-1:0]     cfg_data     = '0;

  line_substring_filter_top #(
    .LINE_BYTES(LINE_BYTES),
    .TERM_BYTES(TERM_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  lsf_pkg::lsf_item_t   text_beats[$];
  lsf_pkg::lsf_result_t out_due[$];
  lsf_pkg::lsf_result_t step_out[$];
  int unsigned beats_queued   = 0;
  int unsigned beats_accepted = 0;
  int unsigned fail_count     = 0;
  int          cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  // filter state as the block should hold it
  logic [63:0] term_lo   = '0;
  logic [63:0] term_hi   = '0;
  logic [4:0]  term_size = '0;
  logic [7:0]  held_bytes [LINE_BYTES-1];
  int unsigned held_count = 0;
  logic [7:0]  win [TERM_BYTES];
  bit          hit_line = 1'b0;
  bit          hit_any  = 1'b0;

  function automatic logic [7:0] term_at(int unsigned k);
    if (k < 8) return term_lo[8*k +: 8];
    if (k < 16) return term_hi[8*(k-8) +: 8];
    return 8'd0;
  endfunction

  function automatic bit window_hits();
    int unsigned len;
    len = term_size;
    if (len == 0 || len > TERM_BYTES || held_count < len) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (win[len-1-i] != term_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    held_count = 0;
    hit_line   = 1'b0;
    for (int i = 0; i < TERM_BYTES; i++) win[i] = 8'd0;
  endtask

  task automatic push_out(logic [7:0] b, logic k, logic s);
    lsf_pkg::lsf_result_t r;
    r.out_byte = b;
    r.kind     = k;
    r.status   = s;
    r.last     = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic emit_line();
    if (hit_line) begin
      hit_any = 1'b1;
      for (int unsigned i = 0; i < held_count; i++)
        push_out(held_bytes[i], lsf_pkg::KIND_LINE, lsf_pkg::STATUS_MATCH);
      push_out(lsf_pkg::CHAR_LF, lsf_pkg::KIND_LINE, lsf_pkg::STATUS_MATCH);
    end
    clear_line();
  endtask

  task automatic apply_text_beat(lsf_pkg::lsf_item_t b);
    lsf_pkg::lsf_result_t r;
    step_out.delete();
    if (b.end_of_input) begin
      if (held_count > 0) emit_line();
      else clear_line();
      push_out(8'd0, lsf_pkg::KIND_STATUS,
               hit_any ? lsf_pkg::STATUS_MATCH : lsf_pkg::STATUS_NOMATCH);
      hit_any = 1'b0;
    end else if (b.in_byte == lsf_pkg::CHAR_CR || b.in_byte == lsf_pkg::CHAR_NUL) begin
    end else if (b.in_byte == lsf_pkg::CHAR_LF) begin
      emit_line();
    end else if (held_count < LINE_BYTES - 1) begin
      held_bytes[held_count] = b.in_byte;
      held_count++;
      for (int i = TERM_BYTES - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b.in_byte;
      if (window_hits()) hit_line = 1'b1;
    end
    for (int i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      out_due.push_back(r);
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        apply_text_beat(item);
        beats_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (text_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= text_beats.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_seen != hold_request) begin
      hold_seen    <= hold_request;
      hold_left    <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report(string field, logic [7:0] want, logic [7:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    lsf_pkg::lsf_result_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (out_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none got %0h", $time, result);
      end else begin
        want = out_due.pop_front();
        if (result.out_byte !== want.out_byte)
          report("out_byte", want.out_byte, result.out_byte);
        if (result.kind !== want.kind) report("kind", want.kind, result.kind);
        if (result.status !== want.status) report("status", want.status, result.status);
        if (result.last !== want.last) report("last", want.last, result.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_beat(logic [7:0] b, logic eoi);
    lsf_pkg::lsf_item_t t;
    t.in_byte      = b;
    t.end_of_input = eoi;
    text_beats.push_back(t);
    beats_queued++;
  endtask

  task automatic settle();
    while (beats_accepted != beats_queued || out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_term(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    term_lo   = lo;
    term_hi   = hi;
    term_size = len;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= lsf_pkg::REG_TERM_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= lsf_pkg::REG_TERM_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= lsf_pkg::REG_TERM_LEN;
    cfg_data  <= {{(lsf_pkg::CFG_W-lsf_pkg::TLEN_W){1'b0}}, len};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_term_char(bit wide);
    logic [7:0] c;
    if (!wide) return 8'h61 + 8'($urandom_range(4));
    c = 8'($urandom_range(255, 1));
    while (c == lsf_pkg::CHAR_LF || c == lsf_pkg::CHAR_CR) c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  function automatic logic [7:0] pick_filler();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60 && term_size >= 1 && term_size <= TERM_BYTES)
      return term_at($urandom_range(term_size - 1));
    if (r < 85) return 8'($urandom_range(8'h7a, 8'h61));
    return 8'($urandom_range(255));
  endfunction

  task automatic set_random_term(int unsigned len, bit wide);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int unsigned k = 0; k < len; k++) begin
      if (k < 8) lo[8*k +: 8] = pick_term_char(wide);
      else hi[8*(k-8) +: 8] = pick_term_char(wide);
    end
    write_term(lo, hi, 5'(len));
  endtask

  task automatic queue_random_text(int unsigned n);
    int unsigned start;
    int unsigned pre;
    int unsigned post;
    int unsigned r;
    start = beats_queued;
    while (beats_queued - start < n) begin
      pre  = ($urandom_range(99) < 10) ? $urandom_range(40, 25) : $urandom_range(12, 0);
      post = $urandom_range(6, 0);
      for (int unsigned j = 0; j < pre; j++) queue_beat(pick_filler(), 1'b0);
      if (term_size >= 1 && term_size <= TERM_BYTES && $urandom_range(1) == 1)
        for (int unsigned j = 0; j < term_size; j++) queue_beat(term_at(j), 1'b0);
      for (int unsigned j = 0; j < post; j++) queue_beat(pick_filler(), 1'b0);
      r = $urandom_range(99);
      if (r < 70) begin
        queue_beat(lsf_pkg::CHAR_LF, 1'b0);
      end else if (r < 80) begin
        queue_beat(lsf_pkg::CHAR_CR, 1'b0);
        queue_beat(lsf_pkg::CHAR_LF, 1'b0);
      end else if (r < 92) begin
        queue_beat(8'($urandom_range(255)), 1'b1);
      end
      if ($urandom_range(99) < 4) queue_beat(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic random_phase(int unsigned send_pct, int unsigned stall_p, int unsigned len,
                              bit wide, bit hold);
    settle();
    set_random_term(len, wide);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
    if (hold) hold_request++;
    queue_random_text(RANDOM_PER_PHASE);
  endtask

  initial begin
    clear_line();
    for (int i = 0; i < LINE_BYTES - 1; i++) held_bytes[i] = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty term after reset
    queue_beat("a", 1'b0);
    queue_beat(lsf_pkg::CHAR_LF, 1'b0);
    queue_beat(8'h00, 1'b1);
    settle();

    // two byte term, short line, dropped bytes, empty newline
    write_term(64'h0000_0000_0000_6261, '1, 5'd2);
    queue_beat("a", 1'b0);
    queue_beat(lsf_pkg::CHAR_NUL, 1'b0);
    queue_beat(lsf_pkg::CHAR_CR, 1'b0);
    queue_beat("b", 1'b0);
    queue_beat(8'hff, 1'b0);
    queue_beat(lsf_pkg::CHAR_LF, 1'b0);
    queue_beat(lsf_pkg::CHAR_LF, 1'b0);
    queue_beat("x", 1'b0);
    queue_beat(8'h00, 1'b1);
    queue_beat("q", 1'b0);
    queue_beat("z", 1'b0);
    settle();

    // term changed in the middle of a line
    write_term(64'h0000_0000_0000_007a, '0, 5'd1);
    queue_beat("z", 1'b0);
    queue_beat(lsf_pkg::CHAR_LF, 1'b0);
    settle();

    // term longer than the window
    write_term('1, '1, 5'd17);
    queue_beat(8'hff, 1'b0);
    queue_beat(lsf_pkg::CHAR_LF, 1'b0);
    queue_beat(8'hff, 1'b1);
    queue_beat(8'h80, 1'b1);

    random_phase(0, 0, 3, 1'b0, 1'b0);
    random_phase(66, 0, TERM_BYTES, 1'b1, 1'b0);
    random_phase(0, 66, 1, 1'b0, 1'b0);
    random_phase(15, 15, 9, 1'b1, 1'b0);
    random_phase(0, 0, 5, 1'b0, 1'b1);
    settle();

    if (out_due.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
